// ===== sv/magnetometer_minmax_calibrator_macros.svh =====
// assertion helpers shared by the calibrator modules
// the enclosing module must provide clk and arst_n
`ifndef MAGNETOMETER_MINMAX_CALIBRATOR_MACROS_SVH
`define MAGNETOMETER_MINMAX_CALIBRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define MMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("calibrator check failed");
`define MMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("calibrator check failed");
`else
`define MMC_ASSERT_IMP(lbl, ante, cons)
`define MMC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/mmc_pkg.sv =====
package mmc_pkg;

	localparam int DATA_W    = 16;
	localparam int SPAN_W    = DATA_W + 1;
	localparam int PROD_W    = 31;
	localparam int QUO_W     = 30;
	localparam int STEP_BITS = 2;
	localparam int DIV_STEPS = QUO_W / STEP_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int NUM_AXES  = 3;

	localparam logic signed [DATA_W-1:0] LOW_RST   = 16'sd32760;
	localparam logic signed [DATA_W-1:0] HIGH_RST  = -16'sd32760;
	localparam logic signed [DATA_W-1:0] CAL_LOW   = 16'sd32000;
	localparam logic signed [DATA_W-1:0] CAL_HIGH  = -16'sd32000;
	localparam logic signed [PROD_W-1:0] SCALE     = 31'sd10000;
	localparam logic signed [31:0]       OFFSET    = 32'sd5000;
	localparam logic [DATA_W-1:0]        SPAN_RST  = 16'd32;

	typedef enum logic [2:0] {
		REQ_SAMPLE   = 3'd0,
		REQ_START    = 3'd1,
		REQ_END      = 3'd2,
		REQ_LOAD_MIN = 3'd3,
		REQ_LOAD_MAX = 3'd4
	} req_t;

	typedef enum logic {
		REG_AXIS_SWAP = 1'b0,
		REG_MIN_SPAN  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		req_t req;
		logic tracking;
		logic apply;
		logic calc;
		logic div_start;
		logic store_raw;
	} lane_ctrl_t;

	typedef struct packed {
		logic span_ok;
		logic done;
	} lane_stat_t;

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'sh7fff;
		end else if (v < -32'sd32768) begin
			return 16'sh8000;
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

// ===== sv/mmc_div.sv =====
`include "magnetometer_minmax_calibrator_macros.svh"

module mmc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mmc_pkg::QUO_W-1:0]   dividend,
	input  logic [mmc_pkg::DATA_W-1:0]  divisor,
	output logic [mmc_pkg::QUO_W-1:0]   quotient,
	output logic                        done
);

	logic                          busy_q;
	logic                          done_q;
	logic [mmc_pkg::CNT_W-1:0]     cnt_q;
	logic [mmc_pkg::DATA_W-1:0]    rem_q;
	logic [mmc_pkg::DATA_W-1:0]    div_q;
	logic [mmc_pkg::QUO_W-1:0]     quo_q;
	logic [mmc_pkg::DATA_W-1:0]    rem_n;
	logic [mmc_pkg::QUO_W-1:0]     quo_n;
	logic [mmc_pkg::SPAN_W-1:0]    trial;

	// restoring division, two quotient bits a cycle
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < mmc_pkg::STEP_BITS; i++) begin
			trial = {rem_n, quo_n[mmc_pkg::QUO_W-1]};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
				quo_n = {quo_n[mmc_pkg::QUO_W-2:0], 1'b1};
			end else begin
				quo_n = {quo_n[mmc_pkg::QUO_W-2:0], 1'b0};
			end
			rem_n = trial[mmc_pkg::DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + mmc_pkg::CNT_W'(1);
				if (cnt_q == mmc_pkg::CNT_W'(mmc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	`MMC_ASSERT_IMP(a_start_when_idle, start, !busy_q)
	`MMC_ASSERT_NXT(a_done_single, done_q, !done_q)
	`MMC_ASSERT_IMP(a_cnt_range, busy_q, cnt_q < mmc_pkg::CNT_W'(mmc_pkg::DIV_STEPS))

endmodule

// ===== sv/mmc_lane.sv =====
module mmc_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mmc_pkg::lane_ctrl_t               ctrl,
	input  logic signed [mmc_pkg::DATA_W-1:0] din,
	input  logic [mmc_pkg::DATA_W-1:0]        thr,
	output mmc_pkg::lane_stat_t               stat,
	output logic signed [mmc_pkg::DATA_W-1:0] low,
	output logic signed [mmc_pkg::DATA_W-1:0] high,
	output logic signed [mmc_pkg::DATA_W-1:0] result
);

	logic signed [mmc_pkg::DATA_W-1:0] low_q;
	logic signed [mmc_pkg::DATA_W-1:0] high_q;
	logic signed [mmc_pkg::DATA_W-1:0] result_q;
	logic signed [mmc_pkg::DATA_W-1:0] v_q;
	logic signed [mmc_pkg::PROD_W-1:0] prod_s2;
	logic signed [mmc_pkg::SPAN_W-1:0] span_s2;

	logic signed [mmc_pkg::SPAN_W-1:0] span;
	logic signed [mmc_pkg::SPAN_W-1:0] diff;
	logic signed [mmc_pkg::PROD_W-1:0] prod;
	logic [mmc_pkg::QUO_W-1:0]         dividend;
	logic [mmc_pkg::QUO_W-1:0]         quo;
	logic                              div_done;
	logic signed [31:0]                q_signed;
	logic signed [mmc_pkg::DATA_W-1:0] v_inc;
	logic signed [mmc_pkg::DATA_W-1:0] v_dec;

	assign v_inc = mmc_pkg::sat16(32'(din) + 32'sd1);
	assign v_dec = mmc_pkg::sat16(32'(din) - 32'sd1);

	assign span = mmc_pkg::SPAN_W'(high_q) - mmc_pkg::SPAN_W'(low_q);
	assign diff = mmc_pkg::SPAN_W'(v_q) - mmc_pkg::SPAN_W'(low_q);
	assign prod = mmc_pkg::PROD_W'(diff) * mmc_pkg::SCALE;

	// magnitude into the divider, sign put back afterwards (truncates toward zero)
	assign dividend = prod_s2[mmc_pkg::PROD_W-1] ? mmc_pkg::QUO_W'(-prod_s2)
	                                             : prod_s2[mmc_pkg::QUO_W-1:0];
	assign q_signed = prod_s2[mmc_pkg::PROD_W-1] ? -$signed(32'(quo)) : $signed(32'(quo));

	mmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (dividend),
		.divisor  (span_s2[mmc_pkg::DATA_W-1:0]),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= mmc_pkg::LOW_RST;
			high_q   <= mmc_pkg::HIGH_RST;
			result_q <= '0;
		end else begin
			if (ctrl.apply) begin
				unique case (ctrl.req)
					mmc_pkg::REQ_SAMPLE: begin
						if (ctrl.tracking) begin
							if (din > high_q) high_q <= v_inc;
							if (din < low_q) low_q <= v_dec;
						end
					end
					mmc_pkg::REQ_START: begin
						if (!ctrl.tracking) begin
							low_q  <= mmc_pkg::CAL_LOW;
							high_q <= mmc_pkg::CAL_HIGH;
						end
					end
					mmc_pkg::REQ_LOAD_MIN: low_q  <= din;
					mmc_pkg::REQ_LOAD_MAX: high_q <= din;
					default: ;
				endcase
			end
			if (ctrl.store_raw) begin
				result_q <= v_q;
			end else if (div_done) begin
				result_q <= mmc_pkg::sat16(q_signed - mmc_pkg::OFFSET);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			v_q <= din;
		end
		if (ctrl.calc) begin
			prod_s2 <= prod;
			span_s2 <= span;
		end
	end

	assign stat.span_ok = span >= $signed({1'b0, thr});
	assign stat.done    = div_done;
	assign low          = low_q;
	assign high         = high_q;
	assign result       = result_q;

endmodule

// ===== sv/magnetometer_minmax_calibrator.sv =====
// min/max hard-iron calibrator for a 3-axis magnetometer
// request channel: req_valid / req_stall carry one word (req_type plus three
//   signed axis values); the word is taken when req_valid is high and
//   req_stall is low. req_stall is high from acceptance until the result has
//   been moved into the output register
// result channel: res_valid / res_stall carry one word per request, holding
//   the last sample (scaled or raw), the scaled and calibrating flags and
//   the six current bounds
// sequence: a sample that gets scaled passes the setup states (apply, check,
//   load), the per-axis radix-4 divider and its done strobe, then the output
//   load before res_valid; every other request skips the divider
// overlap: the three axis dividers run side by side; the next word is taken
//   only after the output load, so a new word is not accepted while the
//   previous one is still being processed
// the output register frees the request side: a new word is accepted while
//   the previous result still waits; if the receiver stalls, the finished
//   word waits in its final state until the register is free
// reset (arst_n low): bounds go to +/-32760, tracking and scaled clear,
//   stored sample goes to zero, axis_swap = 0, min_span = 32
// registers over the APB-style port: axis_swap at 0x0, min_span at 0x4
`include "magnetometer_minmax_calibrator_macros.svh"

module magnetometer_minmax_calibrator (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [2:0]                         req_type,
	input  logic signed [mmc_pkg::DATA_W-1:0]  sample_x,
	input  logic signed [mmc_pkg::DATA_W-1:0]  sample_y,
	input  logic signed [mmc_pkg::DATA_W-1:0]  sample_z,
	// result channel
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [mmc_pkg::DATA_W-1:0]  out_x,
	output logic signed [mmc_pkg::DATA_W-1:0]  out_y,
	output logic signed [mmc_pkg::DATA_W-1:0]  out_z,
	output logic                               scaled,
	output logic                               calibrating,
	output logic signed [mmc_pkg::DATA_W-1:0]  cal_min_x,
	output logic signed [mmc_pkg::DATA_W-1:0]  cal_max_x,
	output logic signed [mmc_pkg::DATA_W-1:0]  cal_min_y,
	output logic signed [mmc_pkg::DATA_W-1:0]  cal_max_y,
	output logic signed [mmc_pkg::DATA_W-1:0]  cal_min_z,
	output logic signed [mmc_pkg::DATA_W-1:0]  cal_max_z
);

	typedef enum logic [2:0] {
		S_IDLE,   // waiting for a request word
		S_APPLY,  // lanes update their bounds
		S_CHECK,  // spans compared, products registered
		S_LOAD,   // raw store or divider start
		S_DIV,    // dividers running
		S_DONE    // waiting for the output register
	} state_t;

	localparam int N = mmc_pkg::NUM_AXES;

	state_t state_q;

	// configuration
	logic                        axis_swap_q;
	logic [mmc_pkg::DATA_W-1:0]  min_span_q;
	logic [mmc_pkg::DATA_W-1:0]  thr;
	logic                        cfg_wr;

	// architectural flags
	logic tracking_q;
	logic last_scaled_q;
	logic ok_q;

	// request word held for the whole operation
	mmc_pkg::req_t                     req_q;
	logic signed [mmc_pkg::DATA_W-1:0] raw_q [N];
	logic signed [mmc_pkg::DATA_W-1:0] remap [N];
	logic signed [mmc_pkg::DATA_W-1:0] din   [N];

	// lanes
	mmc_pkg::lane_ctrl_t               ctrl;
	mmc_pkg::lane_stat_t               stat  [N];
	logic signed [mmc_pkg::DATA_W-1:0] low   [N];
	logic signed [mmc_pkg::DATA_W-1:0] high  [N];
	logic signed [mmc_pkg::DATA_W-1:0] res   [N];
	logic [N-1:0]                      span_ok;
	logic [N-1:0]                      done;
	logic                              all_ok;
	logic                              all_done;

	// output register
	logic                              res_valid_q;
	logic                              load_out;
	logic signed [mmc_pkg::DATA_W-1:0] out_res_q  [N];
	logic signed [mmc_pkg::DATA_W-1:0] out_low_q  [N];
	logic signed [mmc_pkg::DATA_W-1:0] out_high_q [N];
	logic                              out_scaled_q;
	logic                              out_cal_q;

	// ---------------------------------------------------------------
	// configuration port: word address in paddr[2], always ready
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_swap_q <= 1'b0;
			min_span_q  <= mmc_pkg::SPAN_RST;
		end else if (cfg_wr) begin
			unique case (mmc_pkg::reg_idx_t'(paddr[2]))
				mmc_pkg::REG_AXIS_SWAP: axis_swap_q <= pwdata[0];
				mmc_pkg::REG_MIN_SPAN:  min_span_q  <= pwdata[mmc_pkg::DATA_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (mmc_pkg::reg_idx_t'(paddr[2]))
				mmc_pkg::REG_AXIS_SWAP: prdata = {31'd0, axis_swap_q};
				mmc_pkg::REG_MIN_SPAN:  prdata = {16'd0, min_span_q};
			endcase
		end
	end

	// a zero threshold behaves as one, so a non-positive span is never divided
	assign thr = (min_span_q == '0) ? mmc_pkg::DATA_W'(1) : min_span_q;

	// ---------------------------------------------------------------
	// axis remap: swapped x takes y, swapped y takes the negated x
	// (negating the most negative reading saturates)
	// ---------------------------------------------------------------
	always_comb begin
		remap[0] = axis_swap_q ? raw_q[1] : raw_q[0];
		remap[1] = axis_swap_q ? mmc_pkg::sat16(32'sd0 - 32'(raw_q[0])) : raw_q[1];
		remap[2] = raw_q[2];
		for (int i = 0; i < N; i++) begin
			// bound loads take the word as given, samples take the remapped axes
			din[i] = (req_q == mmc_pkg::REQ_SAMPLE) ? remap[i] : raw_q[i];
		end
	end

	// ---------------------------------------------------------------
	// lane control
	// ---------------------------------------------------------------
	always_comb begin
		ctrl.req       = req_q;
		ctrl.tracking  = tracking_q;
		ctrl.apply     = (state_q == S_APPLY);
		ctrl.calc      = (state_q == S_CHECK);
		ctrl.div_start = (state_q == S_LOAD) && (req_q == mmc_pkg::REQ_SAMPLE) && ok_q;
		ctrl.store_raw = (state_q == S_LOAD) && (req_q == mmc_pkg::REQ_SAMPLE) && !ok_q;
	end

	for (genvar g = 0; g < N; g++) begin : g_lane
		mmc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.din    (din[g]),
			.thr    (thr),
			.stat   (stat[g]),
			.low    (low[g]),
			.high   (high[g]),
			.result (res[g])
		);
		assign span_ok[g] = stat[g].span_ok;
		assign done[g]    = stat[g].done;
	end

	// merge: scaling only when every axis has enough span
	assign all_ok   = &span_ok;
	assign all_done = &done;

	// ---------------------------------------------------------------
	// sequencer and registered handshake outputs
	// ---------------------------------------------------------------
	assign load_out = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tracking_q    <= 1'b0;
			last_scaled_q <= 1'b0;
			ok_q          <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			// a new word may replace the one leaving in the same cycle
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (req_q == mmc_pkg::REQ_START) begin
						tracking_q <= 1'b1;
					end else if (req_q == mmc_pkg::REQ_END) begin
						tracking_q <= 1'b0;
					end
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					ok_q    <= all_ok;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (req_q == mmc_pkg::REQ_SAMPLE && ok_q) begin
						state_q <= S_DIV;
					end else begin
						if (req_q == mmc_pkg::REQ_SAMPLE) begin
							last_scaled_q <= 1'b0;
						end
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (all_done) begin
						last_scaled_q <= 1'b1;
						state_q       <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	// request capture and result snapshot
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q    <= mmc_pkg::req_t'(req_type);
			raw_q[0] <= sample_x;
			raw_q[1] <= sample_y;
			raw_q[2] <= sample_z;
		end
		if (load_out) begin
			for (int i = 0; i < N; i++) begin
				out_res_q[i]  <= res[i];
				out_low_q[i]  <= low[i];
				out_high_q[i] <= high[i];
			end
			out_scaled_q <= last_scaled_q;
			out_cal_q    <= tracking_q;
		end
	end

	assign out_x       = out_res_q[0];
	assign out_y       = out_res_q[1];
	assign out_z       = out_res_q[2];
	assign scaled      = out_scaled_q;
	assign calibrating = out_cal_q;
	assign cal_min_x   = out_low_q[0];
	assign cal_max_x   = out_high_q[0];
	assign cal_min_y   = out_low_q[1];
	assign cal_max_y   = out_high_q[1];
	assign cal_min_z   = out_low_q[2];
	assign cal_max_z   = out_high_q[2];

	`MMC_ASSERT_NXT(a_accept_to_apply, req_valid && !req_stall, state_q == S_APPLY)
	`MMC_ASSERT_IMP(a_done_only_in_div, done[0], state_q == S_DIV)
	`MMC_ASSERT_NXT(a_hold_until_free, state_q == S_DONE && res_valid_q && res_stall, state_q == S_DONE)

endmodule
